@@ hw/rtl/arm64_lsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// arm64_lsfd_pkg
// Types, instruction masks and result codes for the load/store fault decoder.
// ----------------------------------------------------------------------------
package arm64_lsfd_pkg;

   // instruction match masks
   localparam logic [31:0] PAIR_MASK  = 32'h3A00_0000;
   localparam logic [31:0] PAIR_MATCH = 32'h2800_0000;
   localparam logic [31:0] ATOM_MASK  = 32'h3F20_0C00;
   localparam logic [31:0] ATOM_MATCH = 32'h3820_0000;
   localparam logic [31:0] CAS_MASK   = 32'h3FA0_7C00;
   localparam logic [31:0] CAS_MATCH  = 32'h08A0_7C00;
   localparam logic [31:0] EXCL_MASK  = 32'h3F20_0000;
   localparam logic [31:0] EXCL_MATCH = 32'h0800_0000;

   // access classes
   localparam logic [2:0] CLASS_PAIR     = 3'd0;
   localparam logic [2:0] CLASS_ATOMIC   = 3'd1;
   localparam logic [2:0] CLASS_CAS      = 3'd2;
   localparam logic [2:0] CLASS_EXCL     = 3'd3;
   localparam logic [2:0] CLASS_SINGLE   = 3'd4;
   localparam logic [2:0] CLASS_PREFETCH = 3'd5;

   // extension modes
   localparam logic [1:0] EXT_ZERO  = 2'd0;
   localparam logic [1:0] EXT_SIGN64 = 2'd1;

   // atomic operations
   localparam logic [2:0] ATOP_SWAP = 3'd4;

   // addressing mode field values
   localparam logic [1:0] MODE_POST = 2'd1;
   localparam logic [1:0] MODE_REG  = 2'd2;
   localparam logic [1:0] PAIR_POST = 2'd1;
   localparam logic [1:0] PAIR_PRE  = 2'd3;

   // csr register indexes
   localparam logic [1:0] CSR_WINDOW_LOW  = 2'd0;
   localparam logic [1:0] CSR_WINDOW_HIGH = 2'd1;
   localparam logic [1:0] CSR_RELOC_OFS   = 2'd2;

   typedef struct packed {
      logic [31:0] instruction_word;
      logic [63:0] fault_address;
   } req_type;

   typedef struct packed {
      logic        handled;
      logic [2:0]  access_class;
      logic        is_load;
      logic        is_vector;
      logic [63:0] real_address;
      logic [4:0]  element_bytes;
      logic [1:0]  extend_mode;
      logic [2:0]  atomic_op;
      logic        status_zero_write;
      logic        base_writeback;
      logic [4:0]  base_register;
      logic [63:0] base_value;
   } rsp_type;

endpackage

@@ hw/rtl/arm64_load_store_fault_decoder.sv @@
// ----------------------------------------------------------------------------
// arm64_load_store_fault_decoder
// Classifies one faulting AArch64 load/store and reports relocation and
// base writeback information for it.
// ----------------------------------------------------------------------------
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   req     | req_valid/req_ready/req_payload | instruction word, fault address
//   rsp     | rsp_valid/rsp_ready/rsp_payload | decode result
//   csr     | csr_wr_en/csr_index/csr_wdata   | window and offset registers
//
// rsp_valid rises once a req beat has passed the input register and the
// result register; one beat per cycle while rsp_ready stays high.
// the path is an input register, the decode and 64-bit add/compare, then
// the result register.
// reset (synchronous) empties both stages and clears the csr registers.
// a stalled rsp holds its result; req_ready drops only when both stages
// are full and rsp_ready is low.
module arm64_load_store_fault_decoder (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  arm64_lsfd_pkg::req_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output arm64_lsfd_pkg::rsp_type rsp_payload,
   input  logic                    csr_wr_en,
   input  logic [1:0]              csr_index,
   input  logic [63:0]             csr_wdata
);

   logic [63:0] win_low_ff, win_low_in;
   logic [63:0] win_high_ff, win_high_in;
   logic [63:0] reloc_ff, reloc_in;

   logic                    s1_valid_ff, s1_valid_in;
   arm64_lsfd_pkg::req_type s1_req_ff, s1_req_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   arm64_lsfd_pkg::rsp_type rsp_ff, rsp_in;

   logic req_fire, rsp_load, s1_adv;

   logic [31:0] w;
   logic [63:0] va;
   logic [63:0] pair_off, imm9_off;
   logic [2:0]  pair_sh;
   logic [2:0]  lg;
   logic        wb;
   logic        in_window;
   logic        dec_ok;
   arm64_lsfd_pkg::rsp_type dec;

   // handshake and stage control
   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && rsp_load;
   assign req_ready = !s1_valid_ff || rsp_load;
   assign req_fire  = req_valid && req_ready;

   assign s1_valid_in  = req_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   assign s1_req_in    = req_fire ? req_payload : s1_req_ff;
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // csr writes
   always_comb begin
      win_low_in  = win_low_ff;
      win_high_in = win_high_ff;
      reloc_in    = reloc_ff;
      if (csr_wr_en) begin
         case (csr_index)
            arm64_lsfd_pkg::CSR_WINDOW_LOW:  win_low_in  = csr_wdata;
            arm64_lsfd_pkg::CSR_WINDOW_HIGH: win_high_in = csr_wdata;
            arm64_lsfd_pkg::CSR_RELOC_OFS:   reloc_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   // offsets and window check
   assign w  = s1_req_ff.instruction_word;
   assign va = s1_req_ff.fault_address;

   assign pair_sh  = w[26] ? (3'd2 + {1'b0, w[31:30]}) : ((w[31:30] == 2'd2) ? 3'd3 : 3'd2);
   assign pair_off = {{57{w[21]}}, w[21:15]} << pair_sh;
   assign imm9_off = {{55{w[20]}}, w[20:12]};
   assign lg       = {w[23], w[31:30]};
   assign wb       = !w[24] && !w[21] && w[10];

   assign in_window = (win_low_ff != 64'd0) && (va >= win_low_ff) && (va < win_high_ff);

   // instruction form decode
   always_comb begin
      dec    = '0;
      dec_ok = 1'b0;
      if ((w & arm64_lsfd_pkg::PAIR_MASK) == arm64_lsfd_pkg::PAIR_MATCH) begin
         if (w[31:30] != 2'd3) begin
            dec_ok             = 1'b1;
            dec.access_class   = arm64_lsfd_pkg::CLASS_PAIR;
            dec.is_load        = w[22];
            dec.is_vector      = w[26];
            dec.element_bytes  = w[26] ? (5'd4 << w[31:30])
                                       : ((w[31:30] == 2'd2) ? 5'd8 : 5'd4);
            dec.extend_mode    = (!w[26] && w[22] && w[31:30] == 2'd1)
                                 ? arm64_lsfd_pkg::EXT_SIGN64 : arm64_lsfd_pkg::EXT_ZERO;
            if (w[24:23] == arm64_lsfd_pkg::PAIR_POST
                || w[24:23] == arm64_lsfd_pkg::PAIR_PRE) begin
               dec.base_writeback = 1'b1;
               dec.base_register  = w[9:5];
               dec.base_value     = (w[24:23] == arm64_lsfd_pkg::PAIR_POST)
                                    ? va + pair_off : va;
            end
         end
      end else if ((w & arm64_lsfd_pkg::ATOM_MASK) == arm64_lsfd_pkg::ATOM_MATCH) begin
         if ((w[15] && w[14:12] == 3'd0) || (!w[15] && !w[14])) begin
            dec_ok            = 1'b1;
            dec.access_class  = arm64_lsfd_pkg::CLASS_ATOMIC;
            dec.is_load       = 1'b1;
            dec.element_bytes = 5'd1 << w[31:30];
            dec.atomic_op     = w[15] ? arm64_lsfd_pkg::ATOP_SWAP : w[14:12];
         end
      end else if ((w & arm64_lsfd_pkg::CAS_MASK) == arm64_lsfd_pkg::CAS_MATCH) begin
         dec_ok            = 1'b1;
         dec.access_class  = arm64_lsfd_pkg::CLASS_CAS;
         dec.is_load       = 1'b1;
         dec.element_bytes = 5'd1 << w[31:30];
      end else if ((w & arm64_lsfd_pkg::EXCL_MASK) == arm64_lsfd_pkg::EXCL_MATCH) begin
         dec_ok                = 1'b1;
         dec.access_class      = arm64_lsfd_pkg::CLASS_EXCL;
         dec.is_load           = w[22];
         dec.element_bytes     = 5'd1 << w[31:30];
         dec.status_zero_write = !w[22] && !w[23] && (w[20:16] != 5'd31);
      end else if (w[29:27] == 3'b111 && !w[25]
                   && !(!w[24] && w[21] && w[11:10] != arm64_lsfd_pkg::MODE_REG)) begin
         dec.is_vector = w[26];
         if (w[26]) begin
            // simd widths above 16 bytes are rejected
            if (!(w[23] && w[31:30] != 2'd0)) begin
               dec_ok            = 1'b1;
               dec.access_class  = arm64_lsfd_pkg::CLASS_SINGLE;
               dec.is_load       = w[22];
               dec.element_bytes = 5'd1 << lg;
            end
         end else if (w[23:22] == 2'd0) begin
            dec_ok            = 1'b1;
            dec.access_class  = arm64_lsfd_pkg::CLASS_SINGLE;
            dec.element_bytes = 5'd1 << w[31:30];
         end else if (w[31:30] == 2'd3 && w[23:22] == 2'd2) begin
            // prefetch, indexed forms unallocated
            if (!wb) begin
               dec_ok            = 1'b1;
               dec.access_class  = arm64_lsfd_pkg::CLASS_PREFETCH;
               dec.element_bytes = 5'd8;
            end
         end else if (!(w[31] && w[23:22] == 2'd3)) begin
            dec_ok            = 1'b1;
            dec.access_class  = arm64_lsfd_pkg::CLASS_SINGLE;
            dec.is_load       = 1'b1;
            dec.element_bytes = 5'd1 << w[31:30];
            dec.extend_mode   = w[23:22] - 2'd1;
         end
         if (dec_ok && wb) begin
            dec.base_writeback = 1'b1;
            dec.base_register  = w[9:5];
            dec.base_value     = (w[11:10] == arm64_lsfd_pkg::MODE_POST) ? va + imm9_off : va;
         end
      end
   end

   // result assembly, all fields zero when not handled
   always_comb begin
      rsp_in = rsp_ff;
      if (s1_adv) begin
         if (in_window && dec_ok) begin
            rsp_in              = dec;
            rsp_in.handled      = 1'b1;
            rsp_in.real_address = va + reloc_ff;
         end else begin
            rsp_in = '0;
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff   <= '0;
         win_high_ff  <= '0;
         reloc_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         win_low_ff   <= win_low_in;
         win_high_ff  <= win_high_in;
         reloc_ff     <= reloc_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // checks
   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("req accepted while both stages full and stalled");

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced item did not reach result stage");

   a_unhandled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.handled) |->
         (rsp_ff.real_address == 64'd0 && rsp_ff.element_bytes == 5'd0
          && !rsp_ff.base_writeback))
      else $error("unhandled result carries nonzero fields");

   a_no_wb_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.base_writeback) |->
         (rsp_ff.base_value == 64'd0 && rsp_ff.base_register == 5'd0))
      else $error("base value without writeback");

   a_handled_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.handled) |->
         ($onehot(rsp_ff.element_bytes) && rsp_ff.access_class <= arm64_lsfd_pkg::CLASS_PREFETCH))
      else $error("handled result with bad size or class");

endmodule
